// ===== design/pup_pkg.sv =====
// Shared types, constants and character class functions for the picture unit parser.
package pup_pkg;

    localparam int CH_W      = 8;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 31;
    localparam int LEN_W     = 6;

    // Longest accepted digit string inside the parentheses.
    localparam int MAX_REPEAT_DIGITS = 31;

    localparam logic [LEN_W-1:0]   LEN_MAX   = {LEN_W{1'b1}};
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FORM     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_LENGTH   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NONDIGIT = 2'd3;

    localparam logic [CH_W-1:0] CH_NUL    = 8'h00;
    localparam logic [CH_W-1:0] CH_OPEN   = 8'h28;
    localparam logic [CH_W-1:0] CH_CLOSE  = 8'h29;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [CH_W-1:0]     symbol;
        logic [COUNT_W-1:0]  repeat_count;
    } pup_result_t;

    function automatic logic is_ws(input logic [CH_W-1:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    function automatic logic is_digit(input logic [CH_W-1:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_symbol(input logic [CH_W-1:0] c);
        return (c == 8'h39) || (c == 8'h58) || (c == 8'h41) || (c == 8'h56) ||
               (c == 8'h50) || (c == 8'h5A) || (c == 8'h53) || (c == 8'h2A) ||
               (c == 8'h2E) || (c == 8'h2C) || (c == 8'h2F) || (c == 8'h2B) ||
               (c == 8'h2D);
    endfunction

    function automatic logic [CH_W-1:0] to_upper(input logic [CH_W-1:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) ? (c - 8'h20) : c;
    endfunction

endpackage

// ===== design/pup_in_stage.sv =====
// Input register that holds one character beat ahead of the parse logic.
module pup_in_stage (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [pup_pkg::CH_W-1:0] s_ch,
    input  logic                     advance,
    output logic                     beat_valid,
    output logic [pup_pkg::CH_W-1:0] beat_ch
);

    logic                     valid_reg;
    logic [pup_pkg::CH_W-1:0] ch_reg;

    assign s_ready    = !valid_reg || advance;
    assign beat_valid = valid_reg;
    assign beat_ch    = ch_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            ch_reg <= s_ch;
        end
    end

endmodule

// ===== design/pup_core.sv =====
// Parse state registers and the one-step update for each character.
module pup_core (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     step,
    input  logic [pup_pkg::CH_W-1:0] ch,
    output pup_pkg::pup_result_t     result
);

    localparam logic [2:0] PH_LEAD  = 3'd0;
    localparam logic [2:0] PH_SYM   = 3'd1;
    localparam logic [2:0] PH_SYMSP = 3'd2;
    localparam logic [2:0] PH_INNER = 3'd3;
    localparam logic [2:0] PH_BAD   = 3'd4;

    localparam int SUM_W = pup_pkg::LEN_W + 1;
    localparam int MUL_W = pup_pkg::COUNT_W + 4;
    localparam logic [SUM_W-1:0] LEN_LIMIT = SUM_W'(pup_pkg::MAX_REPEAT_DIGITS + 1);

    logic [2:0]                      phase_reg, phase_next;
    logic [pup_pkg::CH_W-1:0]        held_reg, held_next;
    logic [pup_pkg::CH_W-1:0]        last_reg, last_next;
    logic [pup_pkg::LEN_W-1:0]       spaces_reg, spaces_next;
    logic [pup_pkg::LEN_W-1:0]       len_reg, len_next;
    logic                            nondig_reg, nondig_next;
    logic [pup_pkg::COUNT_W-1:0]     acc_reg, acc_next;

    logic                            ws;
    logic [pup_pkg::CH_W-1:0]        upper;
    logic [MUL_W-1:0]                acc_x10;
    logic [SUM_W-1:0]                len_sum;
    logic [SUM_W-1:0]                spaces_inc;
    logic [pup_pkg::STATUS_W-1:0]    st;

    assign ws    = pup_pkg::is_ws(ch);
    assign upper = pup_pkg::to_upper(ch);

    // Times ten as two shifts; the held digit is the previous non-space byte.
    assign acc_x10 = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0}
                   + MUL_W'(last_reg[3:0]);
    assign len_sum = {1'b0, len_reg} + {1'b0, spaces_reg} + SUM_W'(1);
    assign spaces_inc = {1'b0, spaces_reg} + SUM_W'(1);

    always_comb begin
        st = pup_pkg::ST_FORM;
        if ((phase_reg == PH_SYM) || (phase_reg == PH_SYMSP)) begin
            st = pup_pkg::ST_OK;
        end else if (phase_reg == PH_INNER) begin
            if ((len_reg == '0) || (last_reg != pup_pkg::CH_CLOSE)) begin
                st = pup_pkg::ST_FORM;
            end else if ((len_reg == pup_pkg::LEN_W'(1)) || (len_reg == pup_pkg::LEN_MAX) ||
                         ({1'b0, len_reg} > LEN_LIMIT)) begin
                st = pup_pkg::ST_LENGTH;
            end else if (nondig_reg) begin
                st = pup_pkg::ST_NONDIGIT;
            end else begin
                st = pup_pkg::ST_OK;
            end
        end
    end

    always_comb begin
        result.status       = st;
        result.symbol       = (st == pup_pkg::ST_OK) ? held_reg : '0;
        result.repeat_count = '0;
        if (st == pup_pkg::ST_OK) begin
            result.repeat_count = (phase_reg == PH_INNER) ? acc_reg
                                                          : pup_pkg::COUNT_W'(1);
        end
    end

    always_comb begin
        phase_next  = phase_reg;
        held_next   = held_reg;
        last_next   = last_reg;
        spaces_next = spaces_reg;
        len_next    = len_reg;
        nondig_next = nondig_reg;
        acc_next    = acc_reg;
        if (ch == pup_pkg::CH_NUL) begin
            // The terminating byte returns everything to the reset state.
            phase_next  = PH_LEAD;
            held_next   = '0;
            last_next   = '0;
            spaces_next = '0;
            len_next    = '0;
            nondig_next = 1'b0;
            acc_next    = '0;
        end else begin
            unique case (phase_reg)
                PH_LEAD: begin
                    if (!ws) begin
                        if (pup_pkg::is_symbol(upper)) begin
                            held_next  = upper;
                            phase_next = PH_SYM;
                        end else begin
                            phase_next = PH_BAD;
                        end
                    end
                end
                PH_SYM: begin
                    if (ws) begin
                        phase_next = PH_SYMSP;
                    end else if (ch == pup_pkg::CH_OPEN) begin
                        phase_next = PH_INNER;
                    end else begin
                        phase_next = PH_BAD;
                    end
                end
                PH_SYMSP: begin
                    if (!ws) begin
                        phase_next = PH_BAD;
                    end
                end
                PH_INNER: begin
                    if (ws) begin
                        spaces_next = (spaces_reg == pup_pkg::LEN_MAX) ? pup_pkg::LEN_MAX
                                    : spaces_inc[pup_pkg::LEN_W-1:0];
                    end else begin
                        if (len_reg != '0) begin
                            if (pup_pkg::is_digit(last_reg)) begin
                                acc_next = (acc_x10 > MUL_W'(pup_pkg::COUNT_MAX))
                                         ? pup_pkg::COUNT_MAX
                                         : acc_x10[pup_pkg::COUNT_W-1:0];
                            end else begin
                                nondig_next = 1'b1;
                            end
                        end
                        if (spaces_reg != '0) begin
                            nondig_next = 1'b1;
                        end
                        len_next = (len_sum > SUM_W'(pup_pkg::LEN_MAX)) ? pup_pkg::LEN_MAX
                                 : len_sum[pup_pkg::LEN_W-1:0];
                        spaces_next = '0;
                        last_next   = ch;
                    end
                end
                default: begin
                    phase_next = PH_BAD;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_LEAD;
            held_reg   <= '0;
            last_reg   <= '0;
            spaces_reg <= '0;
            len_reg    <= '0;
            nondig_reg <= 1'b0;
            acc_reg    <= '0;
        end else if (step) begin
            phase_reg  <= phase_next;
            held_reg   <= held_next;
            last_reg   <= last_next;
            spaces_reg <= spaces_next;
            len_reg    <= len_next;
            nondig_reg <= nondig_next;
            acc_reg    <= acc_next;
        end
    end

endmodule

// ===== design/picture_unit_parser.sv =====
// Top level of the picture unit parser: input stage, parse core and result register.
//
//   Channel   Direction  Handshake          Payload
//   s_        in         s_valid/s_ready    s_ch (8 bits)
//   m_        out        m_valid/m_ready    m_status, m_symbol, m_repeat_count
//
// One character beat is accepted every cycle unless a zero beat waits behind an untaken
// result; a result is valid once its zero beat has passed the input and result registers.
// Reset (aresetn low, synchronous) empties both registers and clears the parse state.
// A waiting result only stalls the input when another zero beat reaches the core,
// so non-zero beats keep flowing behind an untaken result.
module picture_unit_parser (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [pup_pkg::CH_W-1:0]       s_ch,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [pup_pkg::STATUS_W-1:0]   m_status,
    output logic [pup_pkg::CH_W-1:0]       m_symbol,
    output logic [pup_pkg::COUNT_W-1:0]    m_repeat_count
);

    logic                     beat_valid;
    logic [pup_pkg::CH_W-1:0] beat_ch;
    logic                     beat_end;
    logic                     advance;
    logic                     load;
    pup_pkg::pup_result_t     core_result;

    logic                     out_valid_reg;
    pup_pkg::pup_result_t     out_reg;

    assign beat_end = (beat_ch == pup_pkg::CH_NUL);
    assign advance  = beat_valid && (!beat_end || !out_valid_reg || m_ready);
    assign load     = advance && beat_end;

    pup_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_ch       (s_ch),
        .advance    (advance),
        .beat_valid (beat_valid),
        .beat_ch    (beat_ch)
    );

    pup_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .ch      (beat_ch),
        .result  (core_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            out_reg <= core_result;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_status       = out_reg.status;
    assign m_symbol       = out_reg.symbol;
    assign m_repeat_count = out_reg.repeat_count;

endmodule
